### hw/rtl/kfd_pkg.sv
// Shared types and constants for the KISS frame decoder.
package kfd_pkg;

	// Framing bytes.
	localparam logic [7:0] FEND  = 8'hC0;
	localparam logic [7:0] FESC  = 8'hDB;
	localparam logic [7:0] TFEND = 8'hDC;
	localparam logic [7:0] TFESC = 8'hDD;
	localparam logic [7:0] NEWLINE = 8'h0A;

	// Fixed command codes.
	localparam logic [7:0] CMD_DATA    = 8'h00;
	localparam logic [7:0] CMD_PERSIST = 8'h02;
	localparam logic [7:0] CMD_SLOT    = 8'h03;
	localparam logic [7:0] CMD_SETHW   = 8'h06;

	// Reset value of the reboot command code.
	localparam logic [7:0] REBOOT_CODE_RST = 8'h08;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RAW_MODE    = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REBOOT_CODE = 1'b1;
	localparam int CFG_DATA_W = 8;

	// Stream widths (tdata fields packed from bit 0, padded to whole bytes).
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_TUSER_W = 3;

	// Parser states.
	typedef enum logic [2:0] {
		ST_START = 3'd0,
		ST_END   = 3'd1,
		ST_CMD   = 3'd2,
		ST_P     = 3'd3,
		ST_SLOT  = 3'd4,
		ST_DATA  = 3'd5,
		ST_ESC   = 3'd6
	} kfd_state_t;

	// Frame kinds.
	typedef enum logic [1:0] {
		KIND_RAW  = 2'd0,
		KIND_CTRL = 2'd1,
		KIND_BOOT = 2'd2
	} kfd_kind_t;

	// Event codes.
	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_DATA  = 3'd1,
		EV_END   = 3'd2,
		EV_P     = 3'd3,
		EV_SLOT  = 3'd4,
		EV_HW    = 3'd5,
		EV_HWEND = 3'd6,
		EV_BOOT  = 3'd7
	} kfd_event_t;

	// One decoded result.
	typedef struct packed {
		logic       frame_start;
		logic [7:0] value;
		kfd_event_t event_res;
		logic       accepted;
	} kfd_result_t;

endpackage

### hw/rtl/kfd_core.sv
// Decoder state machine: parser and raw-mode state with combinational byte decision.
module kfd_core import kfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        tx_ready,
	input  logic        raw_mode,
	input  logic [7:0]  reboot_code,
	output kfd_result_t res
);

	kfd_state_t state_q, state_d;
	kfd_kind_t  kind_q, kind_d;
	logic       raw_idle_q, raw_idle_d;

	// State registers advance only when a byte is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_START;
			kind_q     <= KIND_RAW;
			raw_idle_q <= 1'b1;
		end else if (step) begin
			state_q    <= state_d;
			kind_q     <= kind_d;
			raw_idle_q <= raw_idle_d;
		end
	end

	// Route a decoded frame byte by the kind of the open frame.
	function automatic kfd_event_t byte_event(input kfd_kind_t kind);
		kfd_event_t ev;
		case (kind)
			KIND_RAW:  ev = EV_DATA;
			KIND_CTRL: ev = EV_HW;
			default:   ev = EV_NONE;
		endcase
		return ev;
	endfunction

	// Next state and result for the byte at the input.
	always_comb begin
		state_d    = state_q;
		kind_d     = kind_q;
		raw_idle_d = raw_idle_q;
		res        = '0;
		res.accepted  = 1'b1;
		res.event_res = EV_NONE;

		if (raw_mode) begin
			if (raw_idle_q && !tx_ready) begin
				// Transmitter busy: refuse the byte, keep everything.
				res.accepted = 1'b0;
			end else begin
				if (raw_idle_q) begin
					raw_idle_d      = 1'b0;
					res.frame_start = 1'b1;
				end
				if (data_byte == NEWLINE) begin
					res.event_res = EV_END;
					raw_idle_d    = 1'b1;
				end else begin
					res.event_res = EV_DATA;
					res.value     = data_byte;
				end
			end
		end else begin
			unique case (state_q)
				ST_START: begin
					if (data_byte == FEND) state_d = ST_CMD;
				end
				ST_END: begin
					if (data_byte == FEND) state_d = ST_START;
				end
				ST_CMD: begin
					if (data_byte == CMD_DATA) begin
						if (!tx_ready) begin
							res.accepted = 1'b0;
						end else begin
							state_d         = ST_DATA;
							kind_d          = KIND_RAW;
							res.frame_start = 1'b1;
						end
					end else if (data_byte == CMD_SETHW) begin
						state_d = ST_DATA;
						kind_d  = KIND_CTRL;
					end else if (data_byte == CMD_PERSIST) begin
						state_d = ST_P;
					end else if (data_byte == CMD_SLOT) begin
						state_d = ST_SLOT;
					end else if (data_byte == FEND) begin
						// Extra start marker: keep waiting for the command.
						state_d = ST_CMD;
					end else if (data_byte == reboot_code) begin
						state_d = ST_DATA;
						kind_d  = KIND_BOOT;
					end else begin
						state_d = ST_END;
					end
				end
				ST_P: begin
					res.event_res = EV_P;
					res.value     = data_byte;
					state_d       = ST_END;
				end
				ST_SLOT: begin
					res.event_res = EV_SLOT;
					res.value     = data_byte;
					state_d       = ST_END;
				end
				ST_DATA: begin
					if (data_byte == FESC) begin
						state_d = ST_ESC;
					end else if (data_byte == FEND) begin
						case (kind_q)
							KIND_RAW:  res.event_res = EV_END;
							KIND_CTRL: res.event_res = EV_HWEND;
							KIND_BOOT: res.event_res = EV_BOOT;
							default:   res.event_res = EV_NONE;
						endcase
						state_d = ST_START;
					end else begin
						res.event_res = byte_event(kind_q);
						if (res.event_res != EV_NONE) res.value = data_byte;
					end
				end
				ST_ESC: begin
					if (data_byte == TFEND || data_byte == TFESC) begin
						res.event_res = byte_event(kind_q);
						if (res.event_res != EV_NONE) begin
							res.value = (data_byte == TFEND) ? FEND : FESC;
						end
						state_d = ST_DATA;
					end else if (data_byte != FEND) begin
						// Bad escape: drop the rest of the frame.
						state_d = ST_END;
					end
				end
				default: begin
					state_d = ST_START;
				end
			endcase
		end
	end

	// A refused byte must leave the decoder state untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && !res.accepted) |=>
			($stable(state_q) && $stable(kind_q) && $stable(raw_idle_q)))
		else $error("refused byte changed decoder state");

	// A refused byte carries no event and opens no frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!res.accepted) |-> (res.event_res == EV_NONE && !res.frame_start))
		else $error("refused byte produced an event");

	// Only byte-carrying events have a nonzero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.value != 8'h00) |-> (res.event_res == EV_DATA || res.event_res == EV_P ||
			res.event_res == EV_SLOT || res.event_res == EV_HW))
		else $error("value set on an event that carries no byte");

endmodule

### hw/rtl/kiss_frame_decoder.sv
// Top level of the KISS frame decoder: stream ports, configuration and output skid stage.
// The byte decision is combinational; its result beat is registered in the output stage.
// Throughput: one byte per cycle while the skid register is empty.
// A two-entry output stage (result register plus skid register) keeps input
// acceptance going for one beat while the downstream side stalls.
// Reset (arst_n low, asynchronous) empties the output stage, waits for a start
// marker, closes any raw frame, and sets raw_mode to 0 and reboot_code to 8.
module kiss_frame_decoder import kfd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream. s_tdata: data_byte[7:0], tx_ready[8], zero pad [15:9].
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// Result stream. m_tdata: accepted[0], value[8:1], frame_start[9],
	// zero pad [15:10].
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// m_tuser: event_res[2:0].
	output logic [OUT_TUSER_W-1:0] m_tuser,
	// Configuration write channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic        raw_mode_q;
	logic [7:0]  reboot_code_q;
	logic        take_in, take_out;
	kfd_result_t res;
	kfd_result_t out_q, skid_q;
	logic        out_valid_q, skid_valid_q;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q    <= 1'b0;
			reboot_code_q <= REBOOT_CODE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RAW_MODE:    raw_mode_q    <= cfg_data[0];
				CFG_REBOOT_CODE: reboot_code_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	assign s_tready = !skid_valid_q;
	assign take_in  = s_tvalid && s_tready;
	assign take_out = out_valid_q && m_tready;

	kfd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (take_in),
		.data_byte   (s_tdata[7:0]),
		.tx_ready    (s_tdata[8]),
		.raw_mode    (raw_mode_q),
		.reboot_code (reboot_code_q),
		.res         (res)
	);

	// Output stage occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take_out) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= take_in;
			end
		end else if (take_in) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (take_out) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (take_in) begin
				out_q <= res;
			end
		end else if (take_in) begin
			if (!out_valid_q) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b000000, out_q.frame_start, out_q.value, out_q.accepted};
	assign m_tuser  = out_q.event_res;

	// The skid register only fills behind a full result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry without result entry");

	// A beat taken while the result register is stalled must land in the skid register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready && take_in) |=> skid_valid_q)
		else $error("beat lost while output stalled");

	// Input is held off exactly while the skid register is occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !m_tready) |=> (!s_tready && out_valid_q))
		else $error("output stage accepted a beat while full");

endmodule

### test/kiss_frame_decoder_tb.sv
// Self-checking testbench for the KISS frame decoder: random framed traffic against a predictor.
`timescale 1ns / 1ps

module kiss_frame_decoder_tb;
	import kfd_pkg::*;

	localparam int STALL_LIMIT = 2000;

	// Tracks the decoder state and queues the event expected for each byte beat.
	class event_scoreboard;
		bit         raw_mode = 1'b0;
		logic [7:0] reboot_code = REBOOT_CODE_RST;
		kfd_state_t parse_st = ST_START;
		kfd_kind_t  kind = KIND_RAW;
		bit         raw_idle = 1'b1;
		kfd_result_t expected_events[$];
		int errors = 0;

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			if (idx == CFG_RAW_MODE) begin
				raw_mode = d[0];
			end else begin
				reboot_code = d;
			end
		endfunction

		// Decoded frame bytes go out as data, as hardware bytes, or nowhere.
		function kfd_event_t byte_route();
			case (kind)
				KIND_RAW:  return EV_DATA;
				KIND_CTRL: return EV_HW;
				default:   return EV_NONE;
			endcase
		endfunction

		function kfd_result_t decode_byte(logic [7:0] b, logic rdy);
			kfd_result_t r;
			r = '0;
			r.accepted = 1'b1;
			// Raw text mode: lines end at a newline, the first byte needs the radio.
			if (raw_mode) begin
				if (raw_idle) begin
					if (!rdy) begin
						r.accepted = 1'b0;
						return r;
					end
					raw_idle = 1'b0;
					r.frame_start = 1'b1;
				end
				if (b == NEWLINE) begin
					r.event_res = EV_END;
					raw_idle = 1'b1;
				end else begin
					r.event_res = EV_DATA;
					r.value = b;
				end
				return r;
			end
			// KISS framing.
			case (parse_st)
				ST_START: if (b == FEND) parse_st = ST_CMD;
				ST_END:   if (b == FEND) parse_st = ST_START;
				ST_CMD: begin
					if (b == CMD_DATA) begin
						if (!rdy) begin
							r.accepted = 1'b0;
							return r;
						end
						parse_st = ST_DATA;
						kind = KIND_RAW;
						r.frame_start = 1'b1;
					end else if (b == CMD_SETHW) begin
						parse_st = ST_DATA;
						kind = KIND_CTRL;
					end else if (b == CMD_PERSIST) begin
						parse_st = ST_P;
					end else if (b == CMD_SLOT) begin
						parse_st = ST_SLOT;
					end else if (b == FEND) begin
						// An extra start marker keeps waiting for the command.
					end else if (b == reboot_code) begin
						parse_st = ST_DATA;
						kind = KIND_BOOT;
					end else begin
						parse_st = ST_END;
					end
				end
				ST_P: begin
					r.event_res = EV_P;
					r.value = b;
					parse_st = ST_END;
				end
				ST_SLOT: begin
					r.event_res = EV_SLOT;
					r.value = b;
					parse_st = ST_END;
				end
				ST_DATA: begin
					if (b == FESC) begin
						parse_st = ST_ESC;
					end else if (b == FEND) begin
						case (kind)
							KIND_RAW:  r.event_res = EV_END;
							KIND_CTRL: r.event_res = EV_HWEND;
							KIND_BOOT: r.event_res = EV_BOOT;
							default:   r.event_res = EV_NONE;
						endcase
						parse_st = ST_START;
					end else begin
						r.event_res = byte_route();
						if (r.event_res != EV_NONE) r.value = b;
					end
				end
				ST_ESC: begin
					if (b == TFEND || b == TFESC) begin
						r.event_res = byte_route();
						if (r.event_res != EV_NONE) r.value = (b == TFEND) ? FEND : FESC;
						parse_st = ST_DATA;
					end else if (b != FEND) begin
						parse_st = ST_END;
					end
				end
				default: parse_st = ST_START;
			endcase
			return r;
		endfunction

		function void note_byte(logic [7:0] b, logic rdy);
			kfd_result_t r;
			r = decode_byte(b, rdy);
			expected_events.insert(expected_events.size(), r);
		endfunction

		function void check_result(kfd_result_t got);
			kfd_result_t exp;
			if (expected_events.size() == 0) begin
				$display("%0t: result beat with nothing expected: %s acc=%0b ev=%0d val=%02h fs=%0b",
					$time, "got", got.accepted, got.event_res, got.value, got.frame_start);
				errors++;
				return;
			end
			exp = expected_events.pop_front();
			if (got !== exp) begin
				$display("%0t: result mismatch: expected acc=%0b ev=%0d val=%02h fs=%0b,",
					$time, exp.accepted, exp.event_res, exp.value, exp.frame_start);
				$display("%0t:   got acc=%0b ev=%0d val=%02h fs=%0b",
					$time, got.accepted, got.event_res, got.value, got.frame_start);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_RAW_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	event_scoreboard sb = new;
	int n_sent = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	logic [7:0] cur_reboot = REBOOT_CODE_RST;

	kiss_frame_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Downstream stalls at random unless a calm stretch is on.
	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(99) >= 29);
	end

	// Sample every handshake at the clock edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result({m_tdata[9], m_tdata[8:1], m_tuser, m_tdata[0]});
			if (s_tvalid && s_tready) sb.note_byte(s_tdata[7:0], s_tdata[8]);
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
		end
	end

	// Watchdog on cycles without any beat.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == STALL_LIMIT) begin
			$display("[kiss_frame_decoder] ERROR");
			$finish;
		end
	end

	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	// Offer one byte beat, with a random gap ahead of it.
	task automatic send_byte(input logic [7:0] b, input logic rdy);
		while (!no_idle && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, rdy, b};
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	// Stop sending and wait until every expected event has come back.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_events.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write both registers in back-to-back beats.
	task automatic set_mode(input logic raw, input logic [7:0] code);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_RAW_MODE;
		cfg_data <= {7'd0, raw};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_REBOOT_CODE;
		cfg_data <= code;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_reboot = code;
	endtask

	// Mostly well-formed KISS frames with random content, some noise and broken escapes.
	task automatic kiss_traffic(input int target);
		int pick;
		int len;
		int sel;
		bit has_body;
		logic [7:0] b;
		while (n_sent < target) begin
			no_idle = (n_sent >= 200 && n_sent < 330);
			pick = $urandom_range(99);
			has_body = 1'b0;
			if (pick < 8) begin
				// Line noise between frames.
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), rand_bit());
				continue;
			end
			send_byte(FEND, rand_bit());
			if ($urandom_range(9) == 0) send_byte(FEND, rand_bit());
			if (pick < 38) begin
				if ($urandom_range(4) == 0) send_byte(CMD_DATA, 1'b0);
				send_byte(CMD_DATA, 1'b1);
				has_body = 1'b1;
			end else if (pick < 56) begin
				send_byte(CMD_SETHW, rand_bit());
				has_body = 1'b1;
			end else if (pick < 65) begin
				send_byte(CMD_PERSIST, rand_bit());
				send_byte(8'($urandom_range(255)), rand_bit());
			end else if (pick < 74) begin
				send_byte(CMD_SLOT, rand_bit());
				send_byte(8'($urandom_range(255)), rand_bit());
			end else if (pick < 86) begin
				send_byte(cur_reboot, 1'b1);
				has_body = 1'b1;
			end else begin
				do b = 8'($urandom_range(255));
				while (b inside {CMD_DATA, CMD_PERSIST, CMD_SLOT, CMD_SETHW, FEND} ||
					b == cur_reboot);
				send_byte(b, rand_bit());
				repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)), rand_bit());
			end
			if (has_body) begin
				len = $urandom_range(10);
				repeat (len) begin
					sel = $urandom_range(99);
					if (sel < 78) begin
						b = 8'($urandom_range(255));
						if (b == FEND || b == FESC) b = b ^ 8'h01;
						send_byte(b, rand_bit());
					end else if (sel < 92) begin
						send_byte(FESC, rand_bit());
						send_byte(rand_bit() ? TFEND : TFESC, rand_bit());
					end else if (sel < 96) begin
						// FEND inside an escape is ignored and the escape completes later.
						send_byte(FESC, rand_bit());
						send_byte(FEND, rand_bit());
						send_byte(rand_bit() ? TFEND : TFESC, rand_bit());
					end else begin
						// A bad escape byte drops the rest of the frame.
						send_byte(FESC, rand_bit());
						b = 8'($urandom_range(255));
						if (b == TFEND || b == TFESC) b = 8'h5A;
						send_byte(b, rand_bit());
					end
				end
			end
			send_byte(FEND, rand_bit());
		end
		no_idle = 1'b0;
	endtask

	initial begin
		int len;
		logic [7:0] b;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Data frame: refused open, extreme bytes, both escapes, FEND inside an escape.
		send_byte(FEND, 1'b0);
		send_byte(CMD_DATA, 1'b0);
		send_byte(CMD_DATA, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(FESC, 1'b0);
		send_byte(TFEND, 1'b0);
		send_byte(FESC, 1'b1);
		send_byte(FEND, 1'b0);
		send_byte(TFESC, 1'b1);
		send_byte(FEND, 1'b0);
		// Extra start marker, hardware frame cut short by a bad escape.
		send_byte(FEND, 1'b1);
		send_byte(FEND, 1'b0);
		send_byte(CMD_SETHW, 1'b0);
		send_byte(8'h41, 1'b1);
		send_byte(FESC, 1'b1);
		send_byte(8'h99, 1'b0);
		send_byte(FEND, 1'b1);
		// Persistence, slot time, reboot with dropped data, unknown command.
		send_byte(FEND, 1'b0);
		send_byte(CMD_PERSIST, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(FEND, 1'b0);
		send_byte(FEND, 1'b1);
		send_byte(CMD_SLOT, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(FEND, 1'b0);
		send_byte(FEND, 1'b0);
		send_byte(REBOOT_CODE_RST, 1'b0);
		send_byte(8'h55, 1'b1);
		send_byte(FEND, 1'b0);
		send_byte(FEND, 1'b1);
		send_byte(8'h77, 1'b1);
		send_byte(FEND, 1'b0);

		kiss_traffic(380);

		// Reboot code colliding with the data command.
		quiesce();
		set_mode(1'b0, 8'h00);
		kiss_traffic(480);

		// Raw text mode: refused and empty newline frames first.
		quiesce();
		set_mode(1'b1, 8'hFF);
		send_byte(NEWLINE, 1'b0);
		send_byte(NEWLINE, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(NEWLINE, 1'b0);
		while (n_sent < 680) begin
			len = $urandom_range(12);
			for (int i = 0; i <= len; i++) begin
				b = (i == len) ? NEWLINE : 8'($urandom_range(255));
				if (i == 0 && $urandom_range(4) == 0) send_byte(b, 1'b0);
				send_byte(b, (i == 0) ? 1'b1 : rand_bit());
			end
		end

		// Back to KISS with the reboot code on FEND, then a random code.
		quiesce();
		set_mode(1'b0, FEND);
		kiss_traffic(780);
		quiesce();
		set_mode(1'b0, 8'($urandom_range(255)));
		kiss_traffic(950);

		quiesce();
		if (sb.errors == 0 && sb.expected_events.size() == 0) begin
			$display("[kiss_frame_decoder] OK");
		end else begin
			if (sb.expected_events.size() != 0)
				$display("%0t: %0d expected events never arrived", $time,
					sb.expected_events.size());
			$display("[kiss_frame_decoder] ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/kfd_pkg.sv
hw/rtl/kfd_core.sv
hw/rtl/kiss_frame_decoder.sv
test/kiss_frame_decoder_tb.sv
